/* rtl/core/rfd_pkg.sv */
// ----------------------------------------------------------------------------
// rfd_pkg - rangefinder frame deframer package
// shared types and constants for the 15-byte window deframer
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

    localparam int unsigned FRAME_BYTES = 15;
    localparam int unsigned CFG_IDX_W   = 8;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_RNG_HEAD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RNG_TAIL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QRY_HEAD = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QRY_TAIL = 8'd3;

    localparam logic [7:0] RNG_HEAD_RST = 8'hAA;
    localparam logic [7:0] RNG_TAIL_RST = 8'h55;
    localparam logic [7:0] QRY_HEAD_RST = 8'hCC;
    localparam logic [7:0] QRY_TAIL_RST = 8'h33;

    // window fill count
    localparam logic [3:0] FILL_FULL = 4'd15;
    localparam logic [3:0] FILL_LAST = 4'd14;

    localparam logic FRAME_KIND_DATA  = 1'b0;
    localparam logic FRAME_KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [7:0] rng_head;
        logic [7:0] rng_tail;
        logic [7:0] qry_head;
        logic [7:0] qry_tail;
    } cfg_t;

    typedef struct packed {
        logic        frame_kind;
        logic        checksum_good;
        logic [63:0] payload_first_eight;
        logic [31:0] payload_last_four;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/rfd_cell.sv */
// ----------------------------------------------------------------------------
// rfd_cell - window cell
// holds one byte of the window and takes its neighbour's byte on each shift
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_cell (
    input  wire logic       clk,
    input  wire logic       shift_en,
    input  wire logic [7:0] d_in,
    output logic      [7:0] q
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = shift_en ? d_in : data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

`default_nettype wire

/* rtl/core/rfd_match.sv */
// ----------------------------------------------------------------------------
// rfd_match - frame detector
// tests the window as it stands after the incoming byte and builds the result
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_match (
    input  wire logic [7:0]      win [rfd_pkg::FRAME_BYTES],
    input  wire logic [7:0]      rx_byte,
    input  wire logic            full,
    input  wire rfd_pkg::cfg_t   cfg,
    output logic                 hit,
    output rfd_pkg::result_t     result
);

    logic       data_hit;
    logic       query_hit;
    logic [7:0] sum;

    // before the shift, frame byte k sits in cell k+1 and byte 14 is rx_byte
    always_comb
    begin
        data_hit  = full && (win[1] == cfg.rng_head) && (rx_byte == cfg.rng_tail);
        query_hit = full && (win[1] == cfg.qry_head) && (rx_byte == cfg.qry_tail);
        hit       = data_hit || query_hit;

        sum = ((win[2] ^ win[3]) ^ (win[4] ^ win[5]))
            ^ ((win[6] ^ win[7]) ^ (win[8] ^ win[9]))
            ^ ((win[10] ^ win[11]) ^ (win[12] ^ win[13]));

        // data frame wins when both match
        result.frame_kind          = data_hit ? rfd_pkg::FRAME_KIND_DATA
                                              : rfd_pkg::FRAME_KIND_QUERY;
        result.checksum_good       = (sum == win[14]);
        result.payload_first_eight = {win[2], win[3], win[4], win[5],
                                      win[6], win[7], win[8], win[9]};
        result.payload_last_four   = {win[10], win[11], win[12], win[13]};
    end

endmodule

`default_nettype wire

/* rtl/core/rfd_out.sv */
// ----------------------------------------------------------------------------
// rfd_out - result output stage
// output register with a skid entry so the window never waits on one stall
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_out (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire rfd_pkg::result_t push_data,
    output logic                  can_accept,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output rfd_pkg::result_t      out_data
);

    logic             main_valid_reg;
    logic             main_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    rfd_pkg::result_t main_data_reg;
    rfd_pkg::result_t main_data_next;
    rfd_pkg::result_t skid_data_reg;
    rfd_pkg::result_t skid_data_next;
    logic             out_fire;

    assign out_fire   = main_valid_reg && out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || out_fire)
            begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

/* rtl/core/rangefinder_frame_deframer.sv */
// ----------------------------------------------------------------------------
// rangefinder_frame_deframer - fixed-length frame deframer
// 15-byte shift window of cells; header/tail match emits one frame result
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake                  payload
//  s_       in   s_tvalid / s_tready        s_tdata[7:0]  rx_byte
//  m_       out  m_tvalid / m_tready        m_tdata[95:0] payload, m_tuser[1:0] kind, checksum
//  cfg_     in   cfg_valid / cfg_ready      cfg_index[7:0], cfg_data[7:0]
//
//  one word per cycle while s_tready is high: each accepted byte shifts the
//  cell chain and is tested against the headers and tails in the same cycle;
//  a result is registered in the output stage. reset restores the header and
//  tail registers, clears the fill count and empties the output stage; the
//  cells are not reset. s_tready drops only when the output and its skid entry
//  both hold a result; cfg_ready is always high.
//
`default_nettype none

module rangefinder_frame_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // rx_byte
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [63:0] payload_first_eight, [95:64] payload_last_four
    output logic [95:0]      m_tdata,
    // [0] frame_kind, [1] checksum_good
    output logic [1:0]       m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    rfd_pkg::cfg_t    cfg_reg;
    rfd_pkg::cfg_t    cfg_next;
    logic [3:0]       fill_reg;
    logic [3:0]       fill_next;
    logic [3:0]       fill_base;
    logic [7:0]       win [rfd_pkg::FRAME_BYTES];
    logic             s_fire;
    logic             full;
    logic             hit;
    logic             can_accept;
    rfd_pkg::result_t result;
    rfd_pkg::result_t out_data;

    assign cfg_ready = 1'b1;
    assign s_tready  = can_accept;
    assign s_fire    = s_tvalid && can_accept;

    // config registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                rfd_pkg::CFG_RNG_HEAD: cfg_next.rng_head = cfg_data;
                rfd_pkg::CFG_RNG_TAIL: cfg_next.rng_tail = cfg_data;
                rfd_pkg::CFG_QRY_HEAD: cfg_next.qry_head = cfg_data;
                rfd_pkg::CFG_QRY_TAIL: cfg_next.qry_tail = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // cell chain, oldest byte in cell 0
    genvar gi;
    generate
        for (gi = 0; gi < rfd_pkg::FRAME_BYTES; gi++)
        begin : g_cell
            if (gi == rfd_pkg::FRAME_BYTES - 1)
            begin : g_last
                rfd_cell u_cell (
                    .clk      (clk),
                    .shift_en (s_fire),
                    .d_in     (s_tdata),
                    .q        (win[gi])
                );
            end
            else
            begin : g_mid
                rfd_cell u_cell (
                    .clk      (clk),
                    .shift_en (s_fire),
                    .d_in     (win[gi+1]),
                    .q        (win[gi])
                );
            end
        end
    endgenerate

    // window is full once this byte lands
    assign full = (fill_reg >= rfd_pkg::FILL_LAST);

    rfd_match u_match (
        .win     (win),
        .rx_byte (s_tdata),
        .full    (full),
        .cfg     (cfg_reg),
        .hit     (hit),
        .result  (result)
    );

    always_comb
    begin
        fill_base = (fill_reg == rfd_pkg::FILL_FULL) ? rfd_pkg::FILL_LAST : fill_reg;
        fill_next = fill_reg;
        if (s_fire)
        begin
            fill_next = hit ? 4'd0 : fill_base + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg         <= 4'd0;
            cfg_reg.rng_head <= rfd_pkg::RNG_HEAD_RST;
            cfg_reg.rng_tail <= rfd_pkg::RNG_TAIL_RST;
            cfg_reg.qry_head <= rfd_pkg::QRY_HEAD_RST;
            cfg_reg.qry_tail <= rfd_pkg::QRY_TAIL_RST;
        end
        else
        begin
            fill_reg <= fill_next;
            cfg_reg  <= cfg_next;
        end
    end

    rfd_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_fire && hit),
        .push_data  (result),
        .can_accept (can_accept),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    assign m_tdata = {out_data.payload_last_four, out_data.payload_first_eight};
    assign m_tuser = {out_data.checksum_good, out_data.frame_kind};

endmodule

`default_nettype wire

/* rtl/core/rfd_checker.sv */
// ----------------------------------------------------------------------------
// rfd_checker - port checks for the deframer
// watches the top-level ports over time
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [95:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_ready
);

    // nothing on the output while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result word shown during reset");

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // input back-pressure only comes from a full output stage
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output stage empty");

    // the config port is ready whenever s_tvalid is high
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> cfg_ready)
        else $error("config port not ready");

endmodule

bind rangefinder_frame_deframer rfd_checker u_rfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
